// File: design/prx_pkg.sv
// ----------------------------------------------------------------------------
// prx_pkg: shared types and constants of the proximity alert relay controller
// Register map, configuration and queue entry layouts, wheel zone table.
// ----------------------------------------------------------------------------
package prx_pkg;

  localparam int DIST_W   = 14;
  localparam int RDIST_W  = 13;
  localparam int MS_W     = 16;
  localparam int IMG_W    = 4;
  localparam int FREQ_W   = 10;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;
  localparam int NOW_W    = 32;
  localparam int ZONES    = 13;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SIDE_MAX_DIST    = 3'd0,
    REG_REAR_MAX_DIST    = 3'd1,
    REG_REAR_DANGER_DIST = 3'd2,
    REG_SIDE_HOLD_MS     = 3'd3,
    REG_REAR_HOLD_MS     = 3'd4,
    REG_BLINK_PERIOD_MS  = 3'd5,
    REG_SLOW_BEEP_MS     = 3'd6,
    REG_FAST_BEEP_MS     = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [RDIST_W-1:0] side_max_dist;
    logic [RDIST_W-1:0] rear_max_dist;
    logic [RDIST_W-1:0] rear_danger_dist;
    logic [MS_W-1:0]    side_hold_ms;
    logic [MS_W-1:0]    rear_hold_ms;
    logic [MS_W-1:0]    blink_period_ms;
    logic [MS_W-1:0]    slow_beep_ms;
    logic [MS_W-1:0]    fast_beep_ms;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    side_max_dist:    13'd1500,
    rear_max_dist:    13'd2000,
    rear_danger_dist: 13'd800,
    side_hold_ms:     16'd1000,
    rear_hold_ms:     16'd1000,
    blink_period_ms:  16'd300,
    slow_beep_ms:     16'd600,
    fast_beep_ms:     16'd400
  };

  // Classified pass as it waits in the queue.
  typedef struct packed {
    logic               wheel;
    logic               brake;
    logic               left_det;
    logic               right_det;
    logic               rear_det;
    logic [RDIST_W-1:0] rear_dist;
    logic [IMG_W-1:0]   image;
    logic [FREQ_W-1:0]  freq;
    logic [MS_W-1:0]    period;
  } cls_t;

  typedef struct packed {
    logic              left_relay;
    logic              right_relay;
    logic              brake_relay;
    logic              blink_relay;
    logic [1:0]        side_alert;
    logic [IMG_W-1:0]  wheel_image;
    logic [FREQ_W-1:0] tone_freq_hz;
    logic [MS_W-1:0]   tone_period_ms;
  } res_t;

  localparam logic signed [DIST_W-1:0] WHEEL_MIN_DIST = 14'sd200;
  localparam logic signed [DIST_W-1:0] WHEEL_MAX_DIST = 14'sd1000;

  localparam logic [9:0] ZONE_FLOOR [ZONES] = '{
    10'd970, 10'd940, 10'd900, 10'd850, 10'd800, 10'd770, 10'd700,
    10'd640, 10'd570, 10'd540, 10'd500, 10'd450, 10'd200
  };

  localparam logic [IMG_W-1:0] IMG_LAST_SLOW   = 4'd3;
  localparam logic [IMG_W-1:0] IMG_LAST_SLOW_S = 4'd5;
  localparam logic [IMG_W-1:0] IMG_LAST_SLOW_L = 4'd6;
  localparam logic [IMG_W-1:0] IMG_LAST_FAST   = 4'd8;
  localparam logic [IMG_W-1:0] IMG_LAST_FAST_S = 4'd9;
  localparam logic [IMG_W-1:0] IMG_LAST_FAST_L = 4'd10;
  localparam logic [IMG_W-1:0] IMG_CLOSEST     = 4'd13;

  localparam logic [FREQ_W-1:0] FREQ_LOW  = 10'd500;
  localparam logic [FREQ_W-1:0] FREQ_MID  = 10'd700;
  localparam logic [FREQ_W-1:0] FREQ_HIGH = 10'd800;

  localparam logic [MS_W-1:0] BEEP_CUT_SHORT = 16'd100;
  localparam logic [MS_W-1:0] BEEP_CUT_LONG  = 16'd150;

endpackage

// File: design/prx_front.sv
// ----------------------------------------------------------------------------
// prx_front: input classifier
// Turns one input beat into detection flags and the wheel zone, tone and
// beep period, none of which depend on stored state.
// ----------------------------------------------------------------------------
module prx_front (
  input  prx_pkg::cfg_t                      cfg,
  input  logic                               wheel_mode,
  input  logic                               brake_mode,
  input  logic signed [prx_pkg::DIST_W-1:0]  wheel_dist,
  input  logic signed [prx_pkg::DIST_W-1:0]  left_dist,
  input  logic signed [prx_pkg::DIST_W-1:0]  right_dist,
  input  logic signed [prx_pkg::DIST_W-1:0]  rear_dist,
  output prx_pkg::cls_t                      cls
);

  logic                         wheel_in_range;
  logic [prx_pkg::IMG_W-1:0]    image;
  logic [prx_pkg::FREQ_W-1:0]   freq;
  logic [prx_pkg::MS_W-1:0]     period;
  logic [prx_pkg::MS_W-1:0]     slow_s;
  logic [prx_pkg::MS_W-1:0]     slow_l;
  logic [prx_pkg::MS_W-1:0]     fast_s;
  logic [prx_pkg::MS_W-1:0]     fast_l;

  function automatic logic [prx_pkg::MS_W-1:0] sat_sub(
    input logic [prx_pkg::MS_W-1:0] a,
    input logic [prx_pkg::MS_W-1:0] b
  );
    return (a > b) ? a - b : '0;
  endfunction

  function automatic logic in_limit(
    input logic signed [prx_pkg::DIST_W-1:0] d,
    input logic [prx_pkg::RDIST_W-1:0]       lim
  );
    return !d[prx_pkg::DIST_W-1] && (d != '0) && (d[prx_pkg::RDIST_W-1:0] <= lim);
  endfunction

  assign wheel_in_range = (wheel_dist >= prx_pkg::WHEEL_MIN_DIST) &&
                          (wheel_dist <= prx_pkg::WHEEL_MAX_DIST);
  assign slow_s = sat_sub(cfg.slow_beep_ms, prx_pkg::BEEP_CUT_SHORT);
  assign slow_l = sat_sub(cfg.slow_beep_ms, prx_pkg::BEEP_CUT_LONG);
  assign fast_s = sat_sub(cfg.fast_beep_ms, prx_pkg::BEEP_CUT_SHORT);
  assign fast_l = sat_sub(cfg.fast_beep_ms, prx_pkg::BEEP_CUT_LONG);

  // The first floor the distance reaches picks the image; the loop runs
  // downwards so that the match with the highest floor, the farthest zone, wins.
  always_comb begin
    image = prx_pkg::IMG_CLOSEST;
    for (int i = prx_pkg::ZONES - 2; i >= 0; i--) begin
      if (wheel_dist[9:0] >= prx_pkg::ZONE_FLOOR[i]) begin
        image = prx_pkg::IMG_W'(i + 1);
      end
    end
    if (!wheel_in_range) begin
      image = '0;
    end
  end

  always_comb begin
    freq   = '0;
    period = '0;
    if (image == '0) begin
      freq   = '0;
      period = '0;
    end else if (image <= prx_pkg::IMG_LAST_SLOW) begin
      freq   = prx_pkg::FREQ_LOW;
      period = cfg.slow_beep_ms;
    end else if (image <= prx_pkg::IMG_LAST_SLOW_S) begin
      freq   = prx_pkg::FREQ_LOW;
      period = slow_s;
    end else if (image <= prx_pkg::IMG_LAST_SLOW_L) begin
      freq   = prx_pkg::FREQ_LOW;
      period = slow_l;
    end else if (image <= prx_pkg::IMG_LAST_FAST) begin
      freq   = prx_pkg::FREQ_MID;
      period = cfg.fast_beep_ms;
    end else if (image <= prx_pkg::IMG_LAST_FAST_S) begin
      freq   = prx_pkg::FREQ_MID;
      period = fast_s;
    end else if (image <= prx_pkg::IMG_LAST_FAST_L) begin
      freq   = prx_pkg::FREQ_MID;
      period = fast_l;
    end else begin
      freq   = prx_pkg::FREQ_HIGH;
      period = '0;
    end
  end

  always_comb begin
    cls.wheel     = wheel_mode;
    cls.brake     = brake_mode;
    cls.left_det  = in_limit(left_dist, cfg.side_max_dist);
    cls.right_det = in_limit(right_dist, cfg.side_max_dist);
    cls.rear_det  = !brake_mode && in_limit(rear_dist, cfg.rear_max_dist);
    cls.rear_dist = rear_dist[prx_pkg::RDIST_W-1:0];
    cls.image     = image;
    cls.freq      = freq;
    cls.period    = period;
  end

endmodule

// File: design/prx_queue.sv
// ----------------------------------------------------------------------------
// prx_queue: two-entry queue between classifier and executor
// Lets the input side keep taking beats while the executor is stalled.
// ----------------------------------------------------------------------------
module prx_queue #(
  parameter int WIDTH = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic             rd_valid,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [2];
  logic             wr_ptr_r;
  logic             rd_ptr_r;
  logic [1:0]       count_r;

  assign full     = (count_r == 2'd2);
  assign rd_valid = (count_r != 2'd0);
  assign rd_data  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (wr_en) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (rd_en) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      count_r <= count_r + {1'b0, wr_en} - {1'b0, rd_en};
    end
  end

endmodule

// File: design/prx_back.sv
// ----------------------------------------------------------------------------
// prx_back: pass executor
// Applies one classified pass to the hold and blink state and registers
// the result beat.
// ----------------------------------------------------------------------------
module prx_back #(
  parameter int TIME_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  prx_pkg::cfg_t         cfg,
  input  logic                  q_valid,
  input  prx_pkg::cls_t         q_cls,
  input  logic [TIME_WIDTH-1:0] q_now,
  output logic                  q_pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output prx_pkg::res_t         out_res
);

  logic [TIME_WIDTH-1:0]       lseen_r, lseen_nxt;
  logic [TIME_WIDTH-1:0]       rseen_r, rseen_nxt;
  logic [TIME_WIDTH-1:0]       tseen_r, tseen_nxt;
  logic [TIME_WIDTH-1:0]       btog_r, btog_nxt;
  logic                        lvalid_r, lvalid_nxt;
  logic                        rvalid_r, rvalid_nxt;
  logic                        tvalid_r, tvalid_nxt;
  logic                        bon_r, bon_nxt;
  logic [prx_pkg::RDIST_W-1:0] rlast_r, rlast_nxt;
  logic                        out_valid_r;
  prx_pkg::res_t               res_r, res_nxt;
  logic                        al, ar, at, do_tick;

  assign q_pop     = q_valid && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_res   = res_r;

  always_comb begin
    lseen_nxt  = lseen_r;
    rseen_nxt  = rseen_r;
    tseen_nxt  = tseen_r;
    btog_nxt   = btog_r;
    lvalid_nxt = lvalid_r;
    rvalid_nxt = rvalid_r;
    tvalid_nxt = tvalid_r;
    bon_nxt    = bon_r;
    rlast_nxt  = rlast_r;
    res_nxt    = '0;
    al         = 1'b0;
    ar         = 1'b0;
    at         = 1'b0;
    do_tick    = 1'b0;
    if (q_cls.wheel) begin
      lvalid_nxt = 1'b0;
      rvalid_nxt = 1'b0;
      tvalid_nxt = 1'b0;
      lseen_nxt  = '0;
      rseen_nxt  = '0;
      tseen_nxt  = '0;
      res_nxt.wheel_image    = q_cls.image;
      res_nxt.tone_freq_hz   = q_cls.freq;
      res_nxt.tone_period_ms = q_cls.period;
    end else begin
      if (q_cls.brake) begin
        bon_nxt    = 1'b0;
        btog_nxt   = q_now;
        tvalid_nxt = 1'b0;
        tseen_nxt  = '0;
        rlast_nxt  = '0;
      end
      if (q_cls.left_det) begin
        lseen_nxt  = q_now;
        lvalid_nxt = 1'b1;
      end
      if (q_cls.right_det) begin
        rseen_nxt  = q_now;
        rvalid_nxt = 1'b1;
      end
      if (q_cls.rear_det) begin
        tseen_nxt  = q_now;
        tvalid_nxt = 1'b1;
        rlast_nxt  = q_cls.rear_dist;
      end
      al = lvalid_nxt && ((q_now - lseen_nxt) < TIME_WIDTH'(cfg.side_hold_ms));
      ar = rvalid_nxt && ((q_now - rseen_nxt) < TIME_WIDTH'(cfg.side_hold_ms));
      at = tvalid_nxt && ((q_now - tseen_nxt) < TIME_WIDTH'(cfg.rear_hold_ms));
      lvalid_nxt = al;
      rvalid_nxt = ar;
      tvalid_nxt = at;
      res_nxt.left_relay  = al;
      res_nxt.right_relay = ar;
      res_nxt.side_alert  = {ar, al};
      if (at && (rlast_nxt <= cfg.rear_danger_dist)) begin
        res_nxt.brake_relay = 1'b1;
      end else if (at || (al && ar)) begin
        do_tick = 1'b1;
      end
      if (do_tick) begin
        if ((q_now - btog_nxt) >= TIME_WIDTH'(cfg.blink_period_ms)) begin
          bon_nxt  = !bon_nxt;
          btog_nxt = q_now;
        end
        res_nxt.blink_relay = bon_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lseen_r     <= '0;
      rseen_r     <= '0;
      tseen_r     <= '0;
      btog_r      <= '0;
      lvalid_r    <= 1'b0;
      rvalid_r    <= 1'b0;
      tvalid_r    <= 1'b0;
      bon_r       <= 1'b0;
      rlast_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        lseen_r     <= lseen_nxt;
        rseen_r     <= rseen_nxt;
        tseen_r     <= tseen_nxt;
        btog_r      <= btog_nxt;
        lvalid_r    <= lvalid_nxt;
        rvalid_r    <= rvalid_nxt;
        tvalid_r    <= tvalid_nxt;
        bon_r       <= bon_nxt;
        rlast_r     <= rlast_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      res_r <= res_nxt;
    end
  end

endmodule

// File: design/proximity_alert_relay_controller.sv
// ----------------------------------------------------------------------------
// proximity_alert_relay_controller: relay and tone control of a parking aid
// Holds the configuration registers and joins classifier, queue and executor.
// ----------------------------------------------------------------------------
// Each input beat is one control pass: mode buttons, a millisecond time stamp
// and four sensor distances. Each pass gives exactly one result beat with
// the relay states, the side alert kind and, in wheel mode, the zone image,
// tone frequency and beep period. Both channels use valid/ready.
// A beat accepted on the input is written into the queue and then into the
// result register before it appears on the output; one beat per cycle is
// sustained while out_ready stays high; the executor updates state per pop.
// Configuration is written through cfg_wr_en, cfg_index and cfg_wdata, one
// register per cycle, and should only change while no pass is in flight.
// Synchronous reset loads the default register values, drops every hold,
// clears the blink state and empties the queue.
// When the receiver stalls, the result register holds its beat, a two-entry
// queue absorbs further passes, and in_ready falls once the queue is full.
// ----------------------------------------------------------------------------
module proximity_alert_relay_controller #(
  parameter int TIME_WIDTH = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic [prx_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [prx_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_wheel_mode,
  input  logic                                in_brake_mode,
  input  logic [prx_pkg::NOW_W-1:0]           in_now_ms,
  input  logic signed [prx_pkg::DIST_W-1:0]   in_wheel_dist,
  input  logic signed [prx_pkg::DIST_W-1:0]   in_left_dist,
  input  logic signed [prx_pkg::DIST_W-1:0]   in_right_dist,
  input  logic signed [prx_pkg::DIST_W-1:0]   in_rear_dist,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_left_relay,
  output logic                                out_right_relay,
  output logic                                out_brake_relay,
  output logic                                out_blink_relay,
  output logic [1:0]                          out_side_alert,
  output logic [prx_pkg::IMG_W-1:0]           out_wheel_image,
  output logic [prx_pkg::FREQ_W-1:0]          out_tone_freq_hz,
  output logic [prx_pkg::MS_W-1:0]            out_tone_period_ms
);

  localparam int CLS_W = $bits(prx_pkg::cls_t);
  localparam int Q_W   = CLS_W + TIME_WIDTH;

  prx_pkg::cfg_t         cfg_r;
  prx_pkg::cls_t         front_cls;
  prx_pkg::cls_t         q_cls;
  prx_pkg::res_t         res;
  logic [63:0]           now_ext;
  logic [TIME_WIDTH-1:0] now_t;
  logic [TIME_WIDTH-1:0] q_now;
  logic [Q_W-1:0]        q_wr_data;
  logic [Q_W-1:0]        q_rd_data;
  logic                  q_full;
  logic                  q_valid;
  logic                  q_pop;
  logic                  in_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= prx_pkg::CFG_RESET;
    end else if (cfg_wr_en) begin
      case (prx_pkg::cfg_reg_t'(cfg_index))
        prx_pkg::REG_SIDE_MAX_DIST:    cfg_r.side_max_dist    <= cfg_wdata[prx_pkg::RDIST_W-1:0];
        prx_pkg::REG_REAR_MAX_DIST:    cfg_r.rear_max_dist    <= cfg_wdata[prx_pkg::RDIST_W-1:0];
        prx_pkg::REG_REAR_DANGER_DIST: cfg_r.rear_danger_dist <= cfg_wdata[prx_pkg::RDIST_W-1:0];
        prx_pkg::REG_SIDE_HOLD_MS:     cfg_r.side_hold_ms     <= cfg_wdata;
        prx_pkg::REG_REAR_HOLD_MS:     cfg_r.rear_hold_ms     <= cfg_wdata;
        prx_pkg::REG_BLINK_PERIOD_MS:  cfg_r.blink_period_ms  <= cfg_wdata;
        prx_pkg::REG_SLOW_BEEP_MS:     cfg_r.slow_beep_ms     <= cfg_wdata;
        prx_pkg::REG_FAST_BEEP_MS:     cfg_r.fast_beep_ms     <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  assign now_ext   = {32'd0, in_now_ms};
  assign now_t     = now_ext[TIME_WIDTH-1:0];
  assign in_ready  = !q_full;
  assign in_fire   = in_valid && in_ready;
  assign q_wr_data = {now_t, front_cls};
  assign q_cls     = q_rd_data[CLS_W-1:0];
  assign q_now     = q_rd_data[Q_W-1:CLS_W];

  prx_front u_front (
    .cfg        (cfg_r),
    .wheel_mode (in_wheel_mode),
    .brake_mode (in_brake_mode),
    .wheel_dist (in_wheel_dist),
    .left_dist  (in_left_dist),
    .right_dist (in_right_dist),
    .rear_dist  (in_rear_dist),
    .cls        (front_cls)
  );

  prx_queue #(
    .WIDTH (Q_W)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (in_fire),
    .wr_data  (q_wr_data),
    .full     (q_full),
    .rd_en    (q_pop),
    .rd_valid (q_valid),
    .rd_data  (q_rd_data)
  );

  prx_back #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .q_cls     (q_cls),
    .q_now     (q_now),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (res)
  );

  assign out_left_relay     = res.left_relay;
  assign out_right_relay    = res.right_relay;
  assign out_brake_relay    = res.brake_relay;
  assign out_blink_relay    = res.blink_relay;
  assign out_side_alert     = res.side_alert;
  assign out_wheel_image    = res.wheel_image;
  assign out_tone_freq_hz   = res.tone_freq_hz;
  assign out_tone_period_ms = res.tone_period_ms;

`ifndef SYNTHESIS
  a_brake_blink_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_brake_relay && out_blink_relay))
    else $error("brake and blink relays driven in the same beat");

  a_wheel_relays_off: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_wheel_image != '0)) |->
      !(out_left_relay || out_right_relay || out_brake_relay || out_blink_relay))
    else $error("relay driven alongside a wheel zone image");

  a_alert_matches: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_side_alert == {out_right_relay, out_left_relay}))
    else $error("side alert disagrees with side relays");

  a_tone_image: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_tone_freq_hz != '0) == (out_wheel_image != '0)))
    else $error("tone present without zone image or the reverse");
`endif

endmodule

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking testbench of the proximity alert relay controller
// Drives control passes through the valid/ready input channel and checks each
// result beat, field by field, against a cycle-free prediction of the relay,
// hold, blink and wheel zone logic. The registers are written between phases,
// including extreme settings. Both channels idle at random, and the receiver
// holds off once for long enough to fill the block and stall its input.
// ----------------------------------------------------------------------------
module tb;
  import prx_pkg::*;

  localparam int REG_COUNT       = 8;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int CYCLE_LIMIT     = 200000;
  localparam int ZONE_START [13] = '{
    970, 940, 900, 850, 800, 770, 700, 640, 570, 540, 500, 450, 200
  };

  typedef struct {
    logic                     wheel;
    logic                     brake;
    logic [NOW_W-1:0]         now;
    logic signed [DIST_W-1:0] wheel_dist;
    logic signed [DIST_W-1:0] left_dist;
    logic signed [DIST_W-1:0] right_dist;
    logic signed [DIST_W-1:0] rear_dist;
  } pass_t;

  class relay_scoreboard;
    logic [RDIST_W-1:0] side_reach, rear_reach, rear_danger, rear_close_dist;
    logic [MS_W-1:0]    side_hold, rear_hold, blink_every, slow_beep, fast_beep;
    logic [NOW_W-1:0]   left_at, right_at, rear_at, blink_at;
    bit                 left_armed, right_armed, rear_armed, blink_lit;
    res_t               expected_results[$];
    int                 errors;

    function new();
      side_reach  = 13'd1500;
      rear_reach  = 13'd2000;
      rear_danger = 13'd800;
      side_hold   = 16'd1000;
      rear_hold   = 16'd1000;
      blink_every = 16'd300;
      slow_beep   = 16'd600;
      fast_beep   = 16'd400;
      left_at = '0;
      right_at = '0;
      rear_at = '0;
      blink_at = '0;
      left_armed = 1'b0;
      right_armed = 1'b0;
      rear_armed = 1'b0;
      blink_lit = 1'b0;
      rear_close_dist = '0;
      errors = 0;
    endfunction

    function void set_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        REG_SIDE_MAX_DIST:    side_reach  = value[RDIST_W-1:0];
        REG_REAR_MAX_DIST:    rear_reach  = value[RDIST_W-1:0];
        REG_REAR_DANGER_DIST: rear_danger = value[RDIST_W-1:0];
        REG_SIDE_HOLD_MS:     side_hold   = value;
        REG_REAR_HOLD_MS:     rear_hold   = value;
        REG_BLINK_PERIOD_MS:  blink_every = value;
        REG_SLOW_BEEP_MS:     slow_beep   = value;
        REG_FAST_BEEP_MS:     fast_beep   = value;
        default: ;
      endcase
    endfunction

    function logic [NOW_W-1:0] age(logic [NOW_W-1:0] now, logic [NOW_W-1:0] since);
      return now - since;
    endfunction

    function logic [MS_W-1:0] trimmed(logic [MS_W-1:0] base, int cut);
      return (int'(base) > cut) ? MS_W'(int'(base) - cut) : '0;
    endfunction

    function void blink_step(logic [NOW_W-1:0] now);
      if (age(now, blink_at) >= NOW_W'(blink_every)) begin
        blink_lit = !blink_lit;
        blink_at = now;
      end
    endfunction

    function res_t predict_pass(pass_t p);
      res_t r;
      int wd, ld, rd, td, zone;
      bit hl, hr, ht;
      r = '0;
      wd = p.wheel_dist;
      ld = p.left_dist;
      rd = p.right_dist;
      td = p.rear_dist;
      if (p.wheel) begin
        left_armed = 1'b0;
        right_armed = 1'b0;
        rear_armed = 1'b0;
        left_at = '0;
        right_at = '0;
        rear_at = '0;
        if (wd >= 200 && wd <= 1000) begin
          zone = 0;
          while (zone < 12 && wd < ZONE_START[zone]) zone++;
          r.wheel_image = IMG_W'(zone + 1);
          case (zone)
            0, 1, 2: begin
              r.tone_freq_hz = 10'd500;
              r.tone_period_ms = slow_beep;
            end
            3, 4: begin
              r.tone_freq_hz = 10'd500;
              r.tone_period_ms = trimmed(slow_beep, 100);
            end
            5: begin
              r.tone_freq_hz = 10'd500;
              r.tone_period_ms = trimmed(slow_beep, 150);
            end
            6, 7: begin
              r.tone_freq_hz = 10'd700;
              r.tone_period_ms = fast_beep;
            end
            8: begin
              r.tone_freq_hz = 10'd700;
              r.tone_period_ms = trimmed(fast_beep, 100);
            end
            9: begin
              r.tone_freq_hz = 10'd700;
              r.tone_period_ms = trimmed(fast_beep, 150);
            end
            default: begin
              r.tone_freq_hz = 10'd800;
              r.tone_period_ms = '0;
            end
          endcase
        end
      end else begin
        if (p.brake) begin
          blink_lit = 1'b0;
          blink_at = p.now;
          rear_armed = 1'b0;
          rear_at = '0;
          rear_close_dist = '0;
        end
        if (ld > 0 && ld <= int'(side_reach)) begin
          left_at = p.now;
          left_armed = 1'b1;
        end
        if (rd > 0 && rd <= int'(side_reach)) begin
          right_at = p.now;
          right_armed = 1'b1;
        end
        if (!p.brake && td > 0 && td <= int'(rear_reach)) begin
          rear_at = p.now;
          rear_armed = 1'b1;
          rear_close_dist = RDIST_W'(td);
        end
        hl = left_armed && age(p.now, left_at) < NOW_W'(side_hold);
        hr = right_armed && age(p.now, right_at) < NOW_W'(side_hold);
        ht = rear_armed && age(p.now, rear_at) < NOW_W'(rear_hold);
        if (!hl) left_armed = 1'b0;
        if (!hr) right_armed = 1'b0;
        if (!ht) rear_armed = 1'b0;
        r.left_relay = hl;
        r.right_relay = hr;
        r.side_alert = {hr, hl};
        if (ht) begin
          if (rear_close_dist <= rear_danger) begin
            r.brake_relay = 1'b1;
          end else begin
            blink_step(p.now);
            r.blink_relay = blink_lit;
          end
        end else if (hl && hr) begin
          blink_step(p.now);
          r.blink_relay = blink_lit;
        end
      end
      return r;
    endfunction

    function void note_pass(pass_t p);
      expected_results.push_back(predict_pass(p));
    endfunction

    function void mismatch(string field, int want, int got);
      $error("%s: expected %0d, actual %0d", field, want, got);
      errors++;
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (expected_results.size() == 0) begin
        $error("result beat arrived with no pass outstanding");
        errors++;
        return;
      end
      want = expected_results.pop_front();
      if (got.left_relay !== want.left_relay)
        mismatch("left_relay", want.left_relay, got.left_relay);
      if (got.right_relay !== want.right_relay)
        mismatch("right_relay", want.right_relay, got.right_relay);
      if (got.brake_relay !== want.brake_relay)
        mismatch("brake_relay", want.brake_relay, got.brake_relay);
      if (got.blink_relay !== want.blink_relay)
        mismatch("blink_relay", want.blink_relay, got.blink_relay);
      if (got.side_alert !== want.side_alert)
        mismatch("side_alert", want.side_alert, got.side_alert);
      if (got.wheel_image !== want.wheel_image)
        mismatch("wheel_image", want.wheel_image, got.wheel_image);
      if (got.tone_freq_hz !== want.tone_freq_hz)
        mismatch("tone_freq_hz", want.tone_freq_hz, got.tone_freq_hz);
      if (got.tone_period_ms !== want.tone_period_ms)
        mismatch("tone_period_ms", want.tone_period_ms, got.tone_period_ms);
    endfunction

    function int pending();
      return expected_results.size();
    endfunction
  endclass

  logic                     clk = 1'b0;
  logic                     rst_n;
  logic                     cfg_wr_en;
  logic [CFG_IDX_W-1:0]     cfg_index;
  logic [CFG_DATA_W-1:0]    cfg_wdata;
  logic                     in_valid;
  logic                     in_ready;
  logic                     in_wheel_mode;
  logic                     in_brake_mode;
  logic [NOW_W-1:0]         in_now_ms;
  logic signed [DIST_W-1:0] in_wheel_dist;
  logic signed [DIST_W-1:0] in_left_dist;
  logic signed [DIST_W-1:0] in_right_dist;
  logic signed [DIST_W-1:0] in_rear_dist;
  logic                     out_valid;
  logic                     out_ready;
  logic                     out_left_relay;
  logic                     out_right_relay;
  logic                     out_brake_relay;
  logic                     out_blink_relay;
  logic [1:0]               out_side_alert;
  logic [IMG_W-1:0]         out_wheel_image;
  logic [FREQ_W-1:0]        out_tone_freq_hz;
  logic [MS_W-1:0]          out_tone_period_ms;

  relay_scoreboard sb;
  int              hold_off_reqs = 0;
  logic            steady_ready;
  bit              no_gaps;
  logic [NOW_W-1:0] clock_ms;
  int unsigned     cycle_count = 0;

  proximity_alert_relay_controller dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    pass_t seen;
    res_t  got;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        seen.wheel = in_wheel_mode;
        seen.brake = in_brake_mode;
        seen.now = in_now_ms;
        seen.wheel_dist = in_wheel_dist;
        seen.left_dist = in_left_dist;
        seen.right_dist = in_right_dist;
        seen.rear_dist = in_rear_dist;
        sb.note_pass(seen);
      end
      if (out_valid && out_ready) begin
        got = {out_left_relay, out_right_relay, out_brake_relay, out_blink_relay,
               out_side_alert, out_wheel_image, out_tone_freq_hz, out_tone_period_ms};
        sb.check_result(got);
      end
    end
  end

  initial begin
    int hold_offs_done;
    hold_offs_done = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst_n) begin
        out_ready <= 1'b0;
      end else if (hold_off_reqs != hold_offs_done) begin
        hold_offs_done++;
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        out_ready <= 1'b1;
      end else if (steady_ready) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(99) >= 32);
      end
    end
  end

  task automatic send_pass(pass_t p);
    in_valid <= 1'b1;
    in_wheel_mode <= p.wheel;
    in_brake_mode <= p.brake;
    in_now_ms <= p.now;
    in_wheel_dist <= p.wheel_dist;
    in_left_dist <= p.left_dist;
    in_right_dist <= p.right_dist;
    in_rear_dist <= p.rear_dist;
    do @(posedge clk); while (!in_ready);
    if (!no_gaps) begin
      while ($urandom_range(99) < 32) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
  endtask

  task automatic send_fields(bit wheel, bit brake, logic [NOW_W-1:0] now,
                             int wd, int ld, int rd, int td);
    pass_t p;
    p.wheel = wheel;
    p.brake = brake;
    p.now = now;
    p.wheel_dist = DIST_W'(wd);
    p.left_dist = DIST_W'(ld);
    p.right_dist = DIST_W'(rd);
    p.rear_dist = DIST_W'(td);
    send_pass(p);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_regs(logic [CFG_DATA_W-1:0] regs [REG_COUNT]);
    for (int i = 0; i < REG_COUNT; i++) begin
      cfg_wr_en <= 1'b1;
      cfg_index <= cfg_reg_t'(i);
      cfg_wdata <= regs[i];
      sb.set_reg(cfg_reg_t'(i), regs[i]);
      @(posedge clk);
    end
    cfg_wr_en <= 1'b0;
  endtask

  function automatic logic [CFG_DATA_W-1:0] random_reg(cfg_reg_t idx);
    int roll;
    roll = $urandom_range(99);
    case (idx)
      REG_SIDE_MAX_DIST, REG_REAR_MAX_DIST, REG_REAR_DANGER_DIST:
        return (roll < 10) ? 16'd0 : (roll < 20) ? 16'd5000 : 16'($urandom_range(0, 5000));
      REG_SIDE_HOLD_MS, REG_REAR_HOLD_MS:
        return (roll < 10) ? 16'd0 : (roll < 20) ? 16'hFFFF :
               (roll < 30) ? 16'($urandom_range(0, 65535)) : 16'($urandom_range(0, 2500));
      REG_BLINK_PERIOD_MS:
        return (roll < 15) ? 16'd1 : (roll < 30) ? 16'($urandom_range(1, 65535)) :
               16'($urandom_range(1, 700));
      default:
        return (roll < 50) ? 16'($urandom_range(150, 1000)) : 16'($urandom_range(150, 65535));
    endcase
  endfunction

  function automatic logic signed [DIST_W-1:0] pick_dist(int mark);
    int v;
    case ($urandom_range(9))
      0: v = -1;
      1: v = 0;
      2, 3, 4, 5: v = mark + int'($urandom_range(0, 400)) - 200;
      6, 7: v = int'($urandom_range(1, (mark > 1) ? mark : 1));
      default: v = int'($urandom_range(1, 5000));
    endcase
    if (v > 5000) v = 5000;
    if (v < -1) v = -1;
    return DIST_W'(v);
  endfunction

  function automatic pass_t random_pass();
    pass_t p;
    int roll;
    roll = $urandom_range(99);
    if (roll < 3)
      clock_ms = $urandom();
    else if (roll < 6)
      clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 600);
    else
      clock_ms = clock_ms + $urandom_range(0, 400);
    p.now = clock_ms;
    p.wheel = ($urandom_range(99) < 20);
    p.brake = ($urandom_range(99) < 15);
    p.wheel_dist = ($urandom_range(99) < 75) ? DIST_W'($urandom_range(180, 1020))
                                             : pick_dist(1000);
    p.left_dist = pick_dist(sb.side_reach);
    p.right_dist = pick_dist(sb.side_reach);
    p.rear_dist = pick_dist($urandom_range(1) ? sb.rear_reach : sb.rear_danger);
    return p;
  endfunction

  task automatic run_phase(int count, bit pressure, bit steady);
    no_gaps = pressure || steady;
    steady_ready <= steady;
    if (pressure) hold_off_reqs <= hold_off_reqs + 1;
    for (int i = 0; i < count; i++) send_pass(random_pass());
    drain();
    steady_ready <= 1'b0;
    no_gaps = 1'b0;
  endtask

  initial begin
    logic [CFG_DATA_W-1:0] regs [REG_COUNT];
    int wheel_marks [12] = '{-1, 199, 200, 500, 540, 570, 640, 770, 800, 850, 1000, 1001};
    sb = new();
    no_gaps = 1'b0;
    clock_ms = 32'd2000;
    rst_n <= 1'b0;
    cfg_wr_en <= 1'b0;
    cfg_index <= REG_SIDE_MAX_DIST;
    cfg_wdata <= '0;
    in_valid <= 1'b0;
    in_wheel_mode <= 1'b0;
    in_brake_mode <= 1'b0;
    in_now_ms <= '0;
    in_wheel_dist <= '0;
    in_left_dist <= '0;
    in_right_dist <= '0;
    in_rear_dist <= '0;
    steady_ready <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Side detections at the reach boundary, then both sides held so that the
    // blinker toggles; the rear channel at the danger and reach boundaries.
    send_fields(0, 0, 32'd100, -1, 1500, -1, -1);
    send_fields(0, 0, 32'd200, -1, -1, 1501, -1);
    send_fields(0, 0, 32'd300, -1, -1, 1, -1);
    send_fields(0, 0, 32'd1100, -1, -1, -1, 800);
    send_fields(0, 0, 32'd1200, -1, -1, -1, 2000);
    send_fields(0, 1, 32'd1300, -1, 50, 50, 100);
    send_fields(0, 0, 32'd1400, -1, 0, 5000, 0);
    // Holds across the wrap of the time stamp and after a long jump.
    send_fields(0, 0, 32'hFFFF_FF00, -1, 10, -1, 2001);
    send_fields(0, 0, 32'h0000_0100, -1, -1, -1, -1);
    send_fields(0, 0, 32'h8000_0000, -1, -1, 20, -1);
    send_fields(1, 1, 32'h8000_0010, 5000, 10, 10, 10);
    for (int i = 0; i < 12; i++)
      send_fields(1, 0, 32'h8000_0020 + 32'(i), wheel_marks[i], 100, 100, 100);
    send_fields(0, 0, 32'h8000_0040, -1, -1, -1, -1);
    drain();

    regs[REG_SIDE_MAX_DIST] = 16'd5000;
    regs[REG_REAR_MAX_DIST] = 16'd5000;
    regs[REG_REAR_DANGER_DIST] = 16'd0;
    regs[REG_SIDE_HOLD_MS] = 16'hFFFF;
    regs[REG_REAR_HOLD_MS] = 16'd0;
    regs[REG_BLINK_PERIOD_MS] = 16'd1;
    regs[REG_SLOW_BEEP_MS] = 16'd150;
    regs[REG_FAST_BEEP_MS] = 16'hFFFF;
    write_regs(regs);
    run_phase(80, 1'b0, 1'b0);

    regs[REG_SIDE_MAX_DIST] = 16'd0;
    regs[REG_REAR_MAX_DIST] = 16'd0;
    regs[REG_REAR_DANGER_DIST] = 16'd5000;
    regs[REG_SIDE_HOLD_MS] = 16'd0;
    regs[REG_REAR_HOLD_MS] = 16'hFFFF;
    regs[REG_BLINK_PERIOD_MS] = 16'hFFFF;
    regs[REG_SLOW_BEEP_MS] = 16'hFFFF;
    regs[REG_FAST_BEEP_MS] = 16'd150;
    write_regs(regs);
    run_phase(80, 1'b0, 1'b0);

    for (int ph = 0; ph < 11; ph++) begin
      for (int i = 0; i < REG_COUNT; i++) regs[i] = random_reg(cfg_reg_t'(i));
      write_regs(regs);
      run_phase(90, ph == 3, ph == 6);
    end

    drain();
    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("tb: clean");
    else
      $display("tb: errors");
    $finish;
  end

endmodule

// File: sim.f
design/prx_pkg.sv
design/prx_front.sv
design/prx_queue.sv
design/prx_back.sv
design/proximity_alert_relay_controller.sv
tb/tb.sv
